// ===== sv/delimited_frame_deframer_core_assert.svh =====
// Assertion macros shared by the deframer modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef DELIMITED_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define DELIMITED_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define DFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");
// Next-cycle implication, checked out of reset
`define DFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");
`else
`define DFD_ASSERT_IMPL(lbl, ante, cons)
`define DFD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/dfd_pkg.sv =====
// Shared types and constants of the delimited frame deframer.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package dfd_pkg;

  // Frame layout: start, type, length, payload, end
  localparam int unsigned TYPE_OFFSET    = 1;
  localparam int unsigned LEN_OFFSET     = 2;
  localparam int unsigned HDR_BYTES      = 3;
  localparam int unsigned FRAME_OVERHEAD = 4;
  localparam int unsigned TYPE_FLAG_BIT  = 7;

  // Result limit per received byte
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned RES_CNT_W   = 7;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  // Configuration registers
  localparam int unsigned CFG_AW = 1;
  localparam int unsigned CFG_DW = 8;
  localparam logic [CFG_AW-1:0] CFG_START_DELIM = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_END_DELIM   = 1'd1;
  localparam logic [CFG_DW-1:0] START_DELIM_RST = 8'hAA;
  localparam logic [CFG_DW-1:0] END_DELIM_RST   = 8'h55;

  // Controller to datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_APPEND,
    CMD_SRCH_INIT,
    CMD_SRCH_RD,
    CMD_DROP_OFF,
    CMD_CLEAR,
    CMD_RD_LEN,
    CMD_LATCH_LEN,
    CMD_RD_END,
    CMD_DROP1,
    CMD_RD_TYPE,
    CMD_LATCH_TYPE,
    CMD_RD_PAY,
    CMD_PUT,
    CMD_DROP_FRAME,
    CMD_FLUSH
  } dfd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ge_hdr;       // at least a header's worth of bytes held
    logic match;        // last scanned byte is the start delimiter
    logic scan_end;     // every held byte has been scanned
    logic short_frame;  // frame not fully received yet
    logic end_ok;       // byte at frame end is the end delimiter
    logic pay_last;     // current payload result closes the packet
    logic can_push;     // a new result fits in pending/output stages
    logic pend_v;       // a result is waiting in the pending stage
  } dfd_status_t;

  // One result beat, minus the run marker
  typedef struct packed {
    logic       kind;
    logic [6:0] ptype;
    logic       resp;
    logic [5:0] plen;
    logic [7:0] pbyte;
    logic [5:0] idx;
    logic       plast;
  } dfd_result_t;

endpackage

// ===== sv/delimited_frame_deframer_core.sv =====
// Top level of the delimited frame deframer.
// Depends on dfd_pkg, dfd_ctrl and dfd_datapath.
`timescale 1ns / 1ps

// Takes one link byte per input beat into a circular buffer of BUFFER_BYTES
// bytes and pulls out frames laid out as start, type, length, payload, end.
// Each good frame gives one result beat per payload byte (one beat for an
// empty payload); a byte arriving on a full buffer clears it and gives one
// overflow beat (tuser high). tlast marks the last beat of a packet and
// tdata bit 28 the last beat caused by the input byte. An input byte is
// accepted, then makes one scan pass per frame candidate: a test of the
// fill level, the start of the delimiter search with one read per byte
// passed over, and a read of the length and a check of the end byte. A
// good frame adds a read of the type, a read and a put per result beat
// and a drop of the frame. A final step releases the last beat; the
// single-port buffer read sets this pace. The slowest byte meets a buffer
// of back-to-back candidates that each fail the end check. Results wait
// in a pending stage and an output register, so a stalled output holds
// the scan only when both are full.
module delimited_frame_deframer_core #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input: tdata = in_byte[7:0]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dfd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Results: tdata = packet_type[6:0], needs_response[7], payload_length[13:8],
  // payload_byte[21:14], byte_index[27:22], run_last[28], zero[31:29]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dfd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser,  // kind
  output logic                                out_tlast,  // packet_last
  // Register writes: 0 start delimiter, 1 end delimiter
  input  logic                                cfg_wr_en,
  input  logic [dfd_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [dfd_pkg::CFG_DW-1:0]          cfg_wdata
);

  import dfd_pkg::*;

  dfd_cmd_t    cmd;
  dfd_status_t status;

  dfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  dfd_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .status_o   (status)
  );

endmodule

// ===== sv/dfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold the last word while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/dfd_datapath.sv =====
// Deframer datapath: circular byte buffer, scan pointers, result staging.
// Depends on dfd_pkg, dfd_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "delimited_frame_deframer_core_assert.svh"

module dfd_datapath #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dfd_pkg::dfd_cmd_t                   cmd_i,
  input  logic [dfd_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                cfg_wr_en,
  input  logic [dfd_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [dfd_pkg::CFG_DW-1:0]          cfg_wdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dfd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast,
  output dfd_pkg::dfd_status_t                status_o
);

  import dfd_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned LW = (CW > 9) ? CW : 9;

  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        off_r, off_nxt;
  logic                 chk_r, chk_nxt;
  logic [7:0]           plen_r, plen_nxt;
  logic [7:0]           type_r, type_nxt;
  logic [7:0]           idx_r, idx_nxt;
  dfd_result_t          pend_r, pend_nxt;
  logic                 pend_v_r, pend_v_nxt;
  dfd_result_t          out_r, out_nxt;
  logic                 out_rl_r, out_rl_nxt;
  logic                 out_v_r, out_v_nxt;
  logic [RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic [CFG_DW-1:0]    sd_r, sd_nxt;
  logic [CFG_DW-1:0]    ed_r, ed_nxt;

  logic [7:0]    rdata;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [LW-1:0] total;
  logic [LW-1:0] drop_k;
  logic          full;
  logic          out_free;
  logic          pay_last;
  dfd_result_t   put_res;
  dfd_result_t   ovf_res;

  // Map a buffer offset onto the circular RAM address
  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                              input logic [LW-1:0] off);
    logic [LW:0] sum;
    sum = (LW+1)'(base) + (LW+1)'(off);
    if (sum >= (LW+1)'(BUFFER_BYTES)) begin
      sum = sum - (LW+1)'(BUFFER_BYTES);
    end
    return sum[AW-1:0];
  endfunction

  // Frame geometry and flags
  assign total    = LW'(plen_r) + LW'(FRAME_OVERHEAD);
  assign full     = (count_r == CW'(BUFFER_BYTES));
  assign out_free = !out_v_r || out_tready;
  assign pay_last = (plen_r == 8'd0) || ((idx_r + 8'd1) == plen_r);

  assign status_o.ge_hdr      = (count_r >= CW'(HDR_BYTES));
  assign status_o.match       = chk_r && (rdata == sd_r);
  assign status_o.scan_end    = (off_r == count_r);
  assign status_o.short_frame = (LW'(count_r) < total);
  assign status_o.end_ok      = (rdata == ed_r);
  assign status_o.pay_last    = pay_last;
  assign status_o.can_push    = !pend_v_r || out_free;
  assign status_o.pend_v      = pend_v_r;

  // Pick the read offset for the command at hand
  always_comb begin
    raddr = wrap_addr(head_r, LW'(off_r));
    case (cmd_i)
      CMD_RD_LEN:  raddr = wrap_addr(head_r, LW'(LEN_OFFSET));
      CMD_RD_END:  raddr = wrap_addr(head_r, total - LW'(1));
      CMD_RD_TYPE: raddr = wrap_addr(head_r, LW'(TYPE_OFFSET));
      CMD_RD_PAY:  raddr = wrap_addr(head_r, LW'(HDR_BYTES) + LW'(idx_r));
      default:     raddr = wrap_addr(head_r, LW'(off_r));
    endcase
  end

  assign ram_re = cmd_i inside {CMD_SRCH_RD, CMD_RD_LEN, CMD_RD_END, CMD_RD_TYPE, CMD_RD_PAY};
  assign ram_we = (cmd_i == CMD_APPEND) && !full;
  assign waddr  = wrap_addr(head_r, LW'(count_r));

  dfd_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Build the candidate result beats
  always_comb begin
    ovf_res       = '0;
    ovf_res.kind  = 1'b1;
    ovf_res.plast = 1'b1;

    put_res       = '0;
    put_res.ptype = type_r[6:0];
    put_res.resp  = type_r[TYPE_FLAG_BIT];
    put_res.plen  = plen_r[5:0];
    put_res.pbyte = (plen_r == 8'd0) ? 8'd0 : rdata;
    put_res.idx   = idx_r[5:0];
    put_res.plast = pay_last;
  end

  // Amount removed from the front of the buffer
  always_comb begin
    case (cmd_i)
      CMD_DROP_OFF:   drop_k = LW'(off_r) - LW'(1);
      CMD_DROP1:      drop_k = LW'(1);
      CMD_DROP_FRAME: drop_k = total;
      default:        drop_k = '0;
    endcase
  end

  // Next-state logic of the datapath
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    off_nxt     = off_r;
    chk_nxt     = chk_r;
    plen_nxt    = plen_r;
    type_nxt    = type_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    out_nxt     = out_r;
    out_rl_nxt  = out_rl_r;
    out_v_nxt   = out_v_r && !out_tready;
    res_cnt_nxt = res_cnt_r;
    sd_nxt      = sd_r;
    ed_nxt      = ed_r;

    // Register writes
    if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_START_DELIM: sd_nxt = cfg_wdata;
        CFG_END_DELIM:   ed_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (cmd_i)
      CMD_APPEND: begin
        res_cnt_nxt = '0;
        if (full) begin
          head_nxt    = '0;
          count_nxt   = '0;
          pend_nxt    = ovf_res;
          pend_v_nxt  = 1'b1;
          res_cnt_nxt = RES_CNT_W'(1);
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_SRCH_INIT: begin
        off_nxt = '0;
        chk_nxt = 1'b0;
      end
      CMD_SRCH_RD: begin
        off_nxt = off_r + CW'(1);
        chk_nxt = 1'b1;
      end
      CMD_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      CMD_DROP_OFF, CMD_DROP1, CMD_DROP_FRAME: begin
        head_nxt  = wrap_addr(head_r, drop_k);
        count_nxt = CW'(LW'(count_r) - drop_k);
      end
      CMD_LATCH_LEN: plen_nxt = rdata;
      CMD_LATCH_TYPE: begin
        type_nxt = rdata;
        idx_nxt  = '0;
      end
      CMD_PUT: begin
        idx_nxt = idx_r + 8'd1;
        // Shift pending into the output stage, drop beyond the limit
        if (res_cnt_r < RES_CNT_W'(MAX_RESULTS)) begin
          if (pend_v_r) begin
            out_nxt    = pend_r;
            out_rl_nxt = 1'b0;
            out_v_nxt  = 1'b1;
          end
          pend_nxt    = put_res;
          pend_v_nxt  = 1'b1;
          res_cnt_nxt = res_cnt_r + RES_CNT_W'(1);
        end
      end
      CMD_FLUSH: begin
        out_nxt    = pend_r;
        out_rl_nxt = 1'b1;
        out_v_nxt  = 1'b1;
        pend_v_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      off_r     <= '0;
      chk_r     <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      res_cnt_r <= '0;
      sd_r      <= START_DELIM_RST;
      ed_r      <= END_DELIM_RST;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      off_r     <= off_nxt;
      chk_r     <= chk_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
      res_cnt_r <= res_cnt_nxt;
      sd_r      <= sd_nxt;
      ed_r      <= ed_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    plen_r   <= plen_nxt;
    type_r   <= type_nxt;
    idx_r    <= idx_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
    out_rl_r <= out_rl_nxt;
  end

  // Output beat: tdata holds type, response, length, byte, index, run marker
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.plast;
  assign out_tdata  = {3'b000, out_rl_r, out_r.idx, out_r.pbyte, out_r.plen,
                       out_r.resp, out_r.ptype};

  `DFD_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(BUFFER_BYTES))
  `DFD_ASSERT_IMPL(a_res_bound, 1'b1, res_cnt_r <= RES_CNT_W'(MAX_RESULTS))
  `DFD_ASSERT_IMPL(a_put_room, cmd_i == CMD_PUT, !pend_v_r || out_free)

endmodule

// ===== sv/dfd_ctrl.sv =====
// Deframer controller: sequences append, delimiter search, frame checks
// and result emission. Depends on dfd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "delimited_frame_deframer_core_assert.svh"

module dfd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  dfd_pkg::dfd_status_t status_i,
  output dfd_pkg::dfd_cmd_t    cmd_o
);

  import dfd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOP,
    S_SRCH,
    S_HDR,
    S_LEN_WAIT,
    S_LEN_CHK,
    S_END_WAIT,
    S_TYPE_WAIT,
    S_PAY_RD,
    S_PAY_PUT,
    S_DROP,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Pick the command and the next state
  always_comb begin
    state_nxt = state_r;
    cmd_o     = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o     = CMD_APPEND;
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        if (status_i.ge_hdr) begin
          cmd_o     = CMD_SRCH_INIT;
          state_nxt = S_SRCH;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_SRCH: begin
        if (status_i.match) begin
          cmd_o     = CMD_DROP_OFF;
          state_nxt = S_HDR;
        end else if (status_i.scan_end) begin
          cmd_o     = CMD_CLEAR;
          state_nxt = S_FLUSH;
        end else begin
          cmd_o = CMD_SRCH_RD;
        end
      end
      S_HDR: begin
        if (status_i.ge_hdr) begin
          cmd_o     = CMD_RD_LEN;
          state_nxt = S_LEN_WAIT;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_LEN_WAIT: begin
        cmd_o     = CMD_LATCH_LEN;
        state_nxt = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        if (status_i.short_frame) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd_o     = CMD_RD_END;
          state_nxt = S_END_WAIT;
        end
      end
      S_END_WAIT: begin
        if (status_i.end_ok) begin
          cmd_o     = CMD_RD_TYPE;
          state_nxt = S_TYPE_WAIT;
        end else begin
          cmd_o     = CMD_DROP1;
          state_nxt = S_TOP;
        end
      end
      S_TYPE_WAIT: begin
        cmd_o     = CMD_LATCH_TYPE;
        state_nxt = S_PAY_RD;
      end
      S_PAY_RD: begin
        cmd_o     = CMD_RD_PAY;
        state_nxt = S_PAY_PUT;
      end
      S_PAY_PUT: begin
        // Hold until the result stages have room
        if (status_i.can_push) begin
          cmd_o     = CMD_PUT;
          state_nxt = status_i.pay_last ? S_DROP : S_PAY_RD;
        end
      end
      S_DROP: begin
        cmd_o     = CMD_DROP_FRAME;
        state_nxt = S_TOP;
      end
      S_FLUSH: begin
        // Release the last result of this byte with the run marker
        if (!status_i.pend_v) begin
          state_nxt = S_IDLE;
        end else if (status_i.can_push) begin
          cmd_o     = CMD_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `DFD_ASSERT_IMPL(a_idle_drained, in_tready, !status_i.pend_v)
  `DFD_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `DFD_ASSERT_NEXT(a_flush_empty, (state_r == S_FLUSH) && !status_i.pend_v, in_tready)

endmodule

// ===== bench/tb_deframe_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the delimited frame deframer bench: a byte-level predictor and
// the queue of result beats it expects. Depends on dfd_pkg for register codes.

package tb_deframe_pkg;

  import dfd_pkg::*;

  localparam int HOLD_BYTES = 64;

  // One predicted result beat, run marker included
  typedef struct packed {
    logic       kind;
    logic [6:0] ptype;
    logic       resp;
    logic [5:0] plen;
    logic [7:0] pbyte;
    logic [5:0] idx;
    logic       plast;
    logic       run_last;
  } deframe_beat_t;

  class deframe_scoreboard;
    logic [7:0]    held [HOLD_BYTES];
    int            held_cnt;
    logic [7:0]    start_code;
    logic [7:0]    end_code;
    deframe_beat_t want_beats[$];
    int            errors;
    int            beats_checked;
    int            frames_checked;
    int            overflows_checked;

    function new();
      held_cnt = 0;
      start_code = START_DELIM_RST;
      end_code = END_DELIM_RST;
      errors = 0;
      beats_checked = 0;
      frames_checked = 0;
      overflows_checked = 0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
      case (addr)
        CFG_START_DELIM: start_code = value;
        CFG_END_DELIM:   end_code = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return want_beats.size();
    endfunction

    // Drop k bytes from the front of the held bytes
    function void shift_out(int k);
      if (k >= held_cnt) begin
        held_cnt = 0;
      end else begin
        for (int i = 0; i < held_cnt - k; i++) held[i] = held[i + k];
        held_cnt -= k;
      end
    endfunction

    // Append one accepted byte, rescan and queue the beats it causes
    function void note_byte(logic [7:0] b);
      deframe_beat_t run[$];
      deframe_beat_t r;
      int pos;
      int plen;
      int total;
      bit busy;
      logic [7:0] ftype;
      if (held_cnt < HOLD_BYTES) begin
        held[held_cnt] = b;
        held_cnt++;
      end else begin
        // full buffer: clear it, drop the byte, flag overflow
        held_cnt = 0;
        r = '0;
        r.kind = 1'b1;
        r.plast = 1'b1;
        run.push_back(r);
      end
      busy = 1'b1;
      while (busy && held_cnt >= HDR_BYTES) begin
        pos = 0;
        while (pos < held_cnt && held[pos] != start_code) pos++;
        if (pos == held_cnt) begin
          held_cnt = 0;
          busy = 1'b0;
        end else begin
          shift_out(pos);
          if (held_cnt < HDR_BYTES) begin
            busy = 1'b0;
          end else begin
            plen = held[LEN_OFFSET];
            total = plen + FRAME_OVERHEAD;
            if (held_cnt < total) begin
              busy = 1'b0;
            end else if (held[total - 1] != end_code) begin
              shift_out(1);
            end else begin
              ftype = held[TYPE_OFFSET];
              r = '0;
              r.ptype = ftype[6:0];
              r.resp = ftype[TYPE_FLAG_BIT];
              r.plen = 6'(plen);
              if (plen == 0) begin
                r.plast = 1'b1;
                if (run.size() < MAX_RESULTS) run.push_back(r);
              end else begin
                for (int i = 0; i < plen; i++) begin
                  r.pbyte = held[HDR_BYTES + i];
                  r.idx = 6'(i);
                  r.plast = (i + 1 == plen);
                  if (run.size() < MAX_RESULTS) run.push_back(r);
                end
              end
              shift_out(total);
            end
          end
        end
      end
      if (run.size() > 0) run[run.size() - 1].run_last = 1'b1;
      foreach (run[i]) want_beats.push_back(run[i]);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    // Check one accepted result beat against the oldest expectation
    function void check_beat(logic [OUT_TDATA_W-1:0] tdata, logic tuser, logic tlast);
      deframe_beat_t w;
      if (want_beats.size() == 0) begin
        $error("unexpected result beat: tdata 0x%0h, tuser %0d, tlast %0d",
               tdata, tuser, tlast);
        errors++;
        return;
      end
      w = want_beats.pop_front();
      compare("kind", w.kind, tuser);
      compare("packet_type", w.ptype, tdata[6:0]);
      compare("needs_response", w.resp, tdata[7]);
      compare("payload_length", w.plen, tdata[13:8]);
      compare("payload_byte", w.pbyte, tdata[21:14]);
      compare("byte_index", w.idx, tdata[27:22]);
      compare("run_last", w.run_last, tdata[28]);
      compare("tdata_pad", 0, tdata[31:29]);
      compare("packet_last", w.plast, tlast);
      beats_checked++;
      if (w.kind) overflows_checked++;
      else if (w.plast) frames_checked++;
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top-level bench for delimited_frame_deframer_core: drives bytes, frames and
// delimiter writes, and checks every result beat. Depends on tb_deframe_pkg.

module tb_top;

  import dfd_pkg::*;
  import tb_deframe_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_HOLD = 600;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [CFG_DW-1:0]      cfg_wdata = '0;

  deframe_scoreboard sb = new();

  logic [7:0] cur_start = START_DELIM_RST;
  logic [7:0] cur_end = END_DELIM_RST;
  int         burst_left = 0;
  int         bytes_sent = 0;
  int         settings_run = 1;
  int         cycle_cnt = 0;

  delimited_frame_deframer_core #(.BUFFER_BYTES(HOLD_BYTES)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt, sb.pending());
      $display("delimited_frame_deframer_core test failed");
      $finish;
    end
  end

  // Monitor: predict on input beats, check on output beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser, out_tlast);
    end
  end

  // Receiver: switch between stall patterns, plus one long hold-off
  int       rx_mode = 0;
  int       rx_mode_left = 0;
  int       rx_hold_left = 0;
  int       rx_beats = 0;
  bit       rx_hold_done = 1'b0;

  always @(posedge clk) begin
    if (out_tvalid && out_tready) rx_beats <= rx_beats + 1;
    if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (!rx_hold_done && rx_beats >= 1) begin
      rx_hold_done <= 1'b1;
      rx_hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(8, 80);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one byte; gaps fall between bursts of random length
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Send start, type, length, random payload and a good or corrupted end
  task automatic send_frame(input logic [7:0] ftype, input int plen, input bit bad_end);
    send_byte(cur_start);
    send_byte(ftype);
    send_byte(8'(plen));
    for (int i = 0; i < plen; i++) send_byte(8'($urandom_range(0, 255)));
    send_byte(bad_end ? cur_end ^ 8'($urandom_range(1, 255)) : cur_end);
  endtask

  // Hold the input idle until every expected beat is in and the block is idle
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0 || !in_tready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(addr, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_delims(input logic [7:0] s, input logic [7:0] e);
    write_reg(CFG_START_DELIM, s);
    write_reg(CFG_END_DELIM, e);
    cur_start = s;
    cur_end = e;
    settings_run++;
  endtask

  // Mostly good frames with small payloads, some noise and broken frames
  task automatic run_random(input int n_bytes);
    int stop_at;
    int pick;
    int plen;
    int cut;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
        send_frame(8'($urandom_range(0, 255)), plen, 1'b0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 6), 1'b1);
      end else begin
        // truncated frame: header and part of the payload only
        plen = $urandom_range(1, 8);
        cut = $urandom_range(0, plen - 1);
        send_byte(cur_start);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'(plen));
        repeat (cut) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bytes with no start delimiter are flushed
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h12);
    // empty payload
    send_byte(cur_start);
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(cur_end);
    // type with bit 7 set, extreme payload bytes
    send_byte(cur_start);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_end);
    // wrong end delimiter: one byte dropped, rescanned
    send_byte(cur_start);
    send_byte(8'h01);
    send_byte(8'h01);
    send_byte(8'h33);
    send_byte(8'h00);
    // junk ahead of a frame with type 0x80
    send_byte(8'h77);
    send_byte(cur_start);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hA5);
    send_byte(cur_end);
    settle();

    // Default delimiters, random traffic and a frame that exactly fills the buffer
    run_random(8);
    send_frame(8'h7F, HOLD_BYTES - FRAME_OVERHEAD, 1'b0);
    settle();

    // Low extremes for start, high for end; frame too long for the buffer
    set_delims(8'h00, 8'hFF);
    run_random(5);
    settle();
    send_frame(8'h3C, HOLD_BYTES - FRAME_OVERHEAD + 1, 1'b0);
    settle();

    set_delims(8'hFF, 8'h00);
    run_random(6);
    settle();

    // Same value opens and closes a frame
    begin
      logic [7:0] code;
      code = 8'($urandom_range(0, 255));
      set_delims(code, code);
    end
    run_random(5);
    settle();

    $display("Sent %0d bytes over %0d delimiter settings;", bytes_sent, settings_run);
    $display("checked %0d beats, %0d frames, %0d overflows",
             sb.beats_checked, sb.frames_checked, sb.overflows_checked);
    if (sb.errors == 0) begin
      $display("delimited_frame_deframer_core test passed");
    end else begin
      $display("delimited_frame_deframer_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/dfd_pkg.sv
sv/dfd_ram.sv
sv/dfd_datapath.sv
sv/dfd_ctrl.sv
sv/delimited_frame_deframer_core.sv
bench/tb_deframe_pkg.sv
bench/tb_top.sv
